// ===== rtl/pisd_pkg.sv =====
// ----------------------------------------------------------------------------
// pisd_pkg
// Shared types and codes for the packed integer / string deframer.
// ----------------------------------------------------------------------------
package pisd_pkg;

    // deframer phase codes
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_PREFIX = 2'd1;
    localparam logic [1:0] PH_PASS   = 2'd2;
    localparam logic [1:0] PH_SKIP   = 2'd3;

    // configuration register indexes
    localparam logic CFG_PARSE_MODE = 1'b0;
    localparam logic CFG_WIDE_BYTES = 1'b1;

    localparam logic PARSE_MODE_RST = 1'b1;
    localparam logic [2:0] WIDE_BYTES_RST = 3'd2;

    localparam int CFG_DATA_W = 3;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 3;

    typedef struct packed {
        logic       parse_mode;
        logic [2:0] wide_char_bytes;
    } t_cfg;

    typedef struct packed {
        logic [7:0]         payload_byte;
        logic               payload_valid;
        logic               string_done;
        logic               wide_skipped;
        logic signed [31:0] int_value;
        logic               int_valid;
    } t_result;

endpackage

// ===== rtl/pisd_core.sv =====
// ----------------------------------------------------------------------------
// pisd_core
// Per-byte deframer state: prefix decode, string pass-through and wide skip.
// ----------------------------------------------------------------------------
module pisd_core import pisd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  t_cfg       i_cfg,
    output t_result    o_res,
    output logic       o_res_valid
);

    logic [1:0]  r_phase, n_phase;
    logic [31:0] r_acc, n_acc;
    logic [2:0]  r_idx, n_idx;
    logic        r_neg, n_neg;
    logic [31:0] r_rem, n_rem;

    logic        w_done;
    logic [1:0]  w_phase_nxt;
    logic [4:0]  w_shift;
    logic [31:0] w_value;
    logic [31:0] w_cnt;
    logic [31:0] w_rem_dec;

    always_comb begin
        unique case (r_idx)
            3'd1:    w_shift = 5'd6;
            3'd2:    w_shift = 5'd13;
            3'd3:    w_shift = 5'd20;
            default: w_shift = 5'd27;
        endcase
    end

    always_comb begin
        w_phase_nxt = r_phase;
        n_acc       = r_acc;
        n_idx       = r_idx;
        n_neg       = r_neg;
        w_done      = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                n_acc = {26'd0, i_byte[5:0]};
                n_neg = i_byte[7];
                n_idx = 3'd1;
                if (i_byte[6]) begin
                    w_phase_nxt = PH_PREFIX;
                end else begin
                    w_done = 1'b1;
                end
            end
            PH_PREFIX: begin
                n_acc = r_acc | ({25'd0, i_byte[6:0]} << w_shift);
                n_idx = r_idx + 3'd1;
                // fifth byte always ends the prefix
                if (!(i_byte[7] && n_idx < 3'd5)) begin
                    w_done = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign w_value   = n_neg ? (32'd0 - n_acc) : n_acc;
    assign w_cnt     = 32'(w_value * {29'd0, i_cfg.wide_char_bytes});
    assign w_rem_dec = r_rem - 32'd1;

    always_comb begin
        o_res       = '0;
        o_res_valid = 1'b0;
        n_rem       = r_rem;
        n_phase     = w_phase_nxt;
        if (r_phase == PH_PASS || r_phase == PH_SKIP) begin
            n_rem = w_rem_dec;
            if (r_phase == PH_PASS) begin
                o_res.payload_byte  = i_byte;
                o_res.payload_valid = 1'b1;
                o_res_valid         = 1'b1;
            end
            if (w_rem_dec == 32'd0) begin
                n_phase           = PH_IDLE;
                o_res.string_done = 1'b1;
                o_res_valid       = 1'b1;
                if (r_phase == PH_SKIP) begin
                    o_res.wide_skipped = 1'b1;
                end
            end
        end else if (w_done) begin
            n_phase = PH_IDLE;
            if (!i_cfg.parse_mode) begin
                o_res.int_value = w_value;
                o_res.int_valid = 1'b1;
                o_res_valid     = 1'b1;
            end else if (w_value == 32'd0) begin
                o_res.string_done = 1'b1;
                o_res_valid       = 1'b1;
            end else if (!w_value[31]) begin
                // zero skip count ends the skipped string right here
                if (w_cnt == 32'd0) begin
                    o_res.string_done  = 1'b1;
                    o_res.wide_skipped = 1'b1;
                    o_res_valid        = 1'b1;
                end else begin
                    n_rem   = w_cnt;
                    n_phase = PH_SKIP;
                end
            end else begin
                n_rem   = 32'd0 - w_value;
                n_phase = PH_PASS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_acc   <= '0;
            r_idx   <= '0;
            r_neg   <= 1'b0;
            r_rem   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_idx   <= n_idx;
            r_neg   <= n_neg;
            r_rem   <= n_rem;
        end
    end

    a_prefix_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PREFIX |-> (r_idx >= 3'd1 && r_idx <= 3'd4))
        else $error("prefix byte index out of range");

    a_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PASS || r_phase == PH_SKIP) |-> r_rem != 32'd0)
        else $error("pass or skip phase with zero count");

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.int_valid |-> !o_res.payload_valid && !o_res.string_done)
        else $error("integer result mixed with string result");

endmodule

// ===== rtl/packed_int_string_deframer_top.sv =====
// ----------------------------------------------------------------------------
// packed_int_string_deframer_top
// Decodes sign-magnitude packed integers from a byte stream and, in string
// mode, uses them as length prefixes for pass-through or skipped strings.
// ----------------------------------------------------------------------------
//  channel   direction  width   contents
//  s_*       in         8       data_byte
//  m_*       out        40+1+3  payload_byte, int_value, string_done, flags
//  cfg_*     in         1+3     parse_mode, wide_char_bytes
//
//  one byte accepted per cycle while m_* is not stalled; each result is
//  presented from the output register
//  bytes are held in an input register, worked on, and results land in an
//  output register; backpressure on m_* stalls the input register
//  reset is synchronous and active low; config returns to string mode, width 2
// ----------------------------------------------------------------------------
module packed_int_string_deframer_top import pisd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave stream: [7:0] data_byte
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,
    // master stream: [7:0] payload_byte, [39:8] int_value
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic                  o_m_tlast,
    // tuser: [0] payload_valid, [1] wide_skipped, [2] int_valid
    output logic [OUT_USER_W-1:0] o_m_tuser,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg       r_cfg;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;

    logic       w_fire;
    t_result    w_res;
    logic       w_res_valid;

    assign w_fire     = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.parse_mode      <= PARSE_MODE_RST;
            r_cfg.wide_char_bytes <= WIDE_BYTES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PARSE_MODE: r_cfg.parse_mode      <= i_cfg_data[0];
                CFG_WIDE_BYTES: r_cfg.wide_char_bytes <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    pisd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_fire),
        .i_byte      (r_in_byte),
        .i_cfg       (r_cfg),
        .o_res       (w_res),
        .o_res_valid (w_res_valid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= w_res_valid;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.int_value, r_out.payload_byte};
    assign o_m_tlast  = r_out.string_done;
    assign o_m_tuser  = {r_out.int_valid, r_out.wide_skipped, r_out.payload_valid};

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_fire |=> r_in_valid && $stable(r_in_byte))
        else $error("input register lost a byte while stalled");

    a_skip_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1] |-> o_m_tlast && !o_m_tuser[0])
        else $error("skipped flag without a string end");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata[7:0] == 8'd0)
        else $error("payload byte set without payload valid");

endmodule
